@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/pal_pkg.sv @@
// shared constants, codes and types for the positional array list
package pal_pkg;

  localparam int DEPTH  = 64;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LIM_W  = 7;
  localparam int POS_W  = 7;
  localparam int TYPE_W = 3;
  localparam int STAT_W = 2;
  localparam int CMP_W  = ((CNT_W > LIM_W) ? CNT_W : LIM_W) + 1;

  localparam logic [TYPE_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_DELETE = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_GET    = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_FIND   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADPOS   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [POS_W-1:0]  position;
    logic [31:0]       item_value;
  } pal_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [31:0]       read_value;
    logic [POS_W-1:0]  found_position;
    logic [POS_W-1:0]  list_length;
  } pal_rsp_t;

  // command broadcast to every cell
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic             get;
    logic             find;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] key;
    logic [CNT_W-1:0] count;
  } pal_cmd_t;

  // probe wave handed from cell to cell
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] fpos;
    logic [VAL_W-1:0] data;
  } pal_probe_t;

endpackage

@@ hw/rtl/pal_cell.sv @@
// one list slot: holds an entry, shifts with its neighbors, forwards the probe wave
module pal_cell (
  input  logic                       clk,
  input  pal_pkg::pal_cmd_t          cmd,
  input  logic [pal_pkg::IDX_W-1:0]  slot,
  input  logic [pal_pkg::VAL_W-1:0]  below,
  input  logic [pal_pkg::VAL_W-1:0]  above,
  output logic [pal_pkg::VAL_W-1:0]  entry,
  input  pal_pkg::pal_probe_t        probe_in,
  output pal_pkg::pal_probe_t        probe_out
);
  import pal_pkg::*;

  logic       match;
  pal_probe_t probe_next;

  always_ff @(posedge clk) begin
    if (cmd.shift_up) begin
      if (slot == cmd.idx) begin
        entry <= cmd.key;
      end else if (slot > cmd.idx) begin
        entry <= below;
      end
    end else if (cmd.shift_down && (slot >= cmd.idx)) begin
      entry <= above;
    end
  end

  always_comb begin
    match = (cmd.find && (entry == cmd.key) && (CNT_W'(slot) < cmd.count)) ||
            (cmd.get && (slot == cmd.idx));
    probe_next = probe_in;
    // an earlier hit wins, so the first match survives to the end of the row
    if (!probe_in.hit && match) begin
      probe_next.hit  = 1'b1;
      probe_next.fpos = POS_W'({1'b0, slot} + (IDX_W + 1)'(1));
      probe_next.data = entry;
    end
  end

  always_ff @(posedge clk) begin
    probe_out <= probe_next;
  end

endmodule

@@ hw/rtl/pal_ctrl.sv @@
// request decode, length and limit registers, probe timing and result register
module pal_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       request_valid,
  output logic                       request_stall,
  input  pal_pkg::pal_req_t          request,
  input  logic                       limit_we,
  input  logic [pal_pkg::LIM_W-1:0]  limit_data,
  output pal_pkg::pal_cmd_t          cmd,
  input  pal_pkg::pal_probe_t        probe_last,
  output logic                       result_valid,
  input  logic                       result_stall,
  output pal_pkg::pal_rsp_t          result
);
  import pal_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;

  logic [1:0]        state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [LIM_W-1:0]  limit;
  pal_cmd_t          cmd_next;
  logic [STAT_W-1:0] pend_status, pend_status_next;
  logic              result_valid_next;
  pal_rsp_t          result_next;
  logic              accept, load, probe_op;
  logic [CMP_W-1:0]  count_w, pos_w, limit_w, cap_w;
  logic              full, pos_zero;

  assign request_stall = (state != S_IDLE);
  assign accept        = request_valid && !request_stall;

  always_comb begin
    count_w  = CMP_W'(count);
    pos_w    = CMP_W'(request.position);
    limit_w  = CMP_W'(limit);
    cap_w    = (limit_w < CMP_W'(DEPTH)) ? limit_w : CMP_W'(DEPTH);
    full     = (count_w >= cap_w);
    pos_zero = (request.position == '0);
  end

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    count_next        = count;
    cmd_next          = cmd;
    cmd_next.shift_up   = 1'b0;
    cmd_next.shift_down = 1'b0;
    pend_status_next  = pend_status;
    probe_op          = 1'b0;
    load              = 1'b0;
    result_next       = result;
    result_valid_next = result_valid && result_stall;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_next.get     = 1'b0;
          cmd_next.find    = 1'b0;
          cmd_next.key     = request.item_value[VAL_W-1:0];
          cmd_next.count   = count;
          cmd_next.idx     = IDX_W'(pos_w - CMP_W'(1));
          pend_status_next = STAT_OK;
          unique case (request.req_type)
            REQ_APPEND: begin
              if (full) begin
                pend_status_next = STAT_FULL;
              end else begin
                cmd_next.shift_up = 1'b1;
                cmd_next.idx      = IDX_W'(count);
                count_next        = count + CNT_W'(1);
              end
            end
            REQ_INSERT: begin
              if (pos_zero || (pos_w > count_w + CMP_W'(1))) begin
                pend_status_next = STAT_BADPOS;
              end else if (full) begin
                pend_status_next = STAT_FULL;
              end else begin
                cmd_next.shift_up = 1'b1;
                count_next        = count + CNT_W'(1);
              end
            end
            REQ_DELETE: begin
              if (pos_zero || (pos_w > count_w)) begin
                pend_status_next = STAT_BADPOS;
              end else begin
                cmd_next.shift_down = 1'b1;
                count_next          = count - CNT_W'(1);
              end
            end
            REQ_GET: begin
              if (pos_zero || (pos_w > count_w)) begin
                pend_status_next = STAT_BADPOS;
              end else begin
                cmd_next.get = 1'b1;
                probe_op     = 1'b1;
              end
            end
            REQ_FIND: begin
              cmd_next.find = 1'b1;
              probe_op      = 1'b1;
            end
            default: begin
            end
          endcase
          cnt_next   = '0;
          state_next = probe_op ? S_PROBE : S_DONE;
        end
      end
      S_PROBE: begin
        // the counter holds this state until the wave has passed through every cell to the last one
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(DEPTH)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (load) begin
      result_valid_next          = 1'b1;
      result_next.status         = pend_status;
      result_next.read_value     = '0;
      result_next.found_position = '0;
      result_next.list_length    = POS_W'(count);
      if (cmd.get) begin
        result_next.read_value = 32'(probe_last.data);
      end
      if (cmd.find) begin
        if (probe_last.hit) begin
          result_next.status         = STAT_OK;
          result_next.found_position = probe_last.fpos;
        end else begin
          result_next.status = STAT_NOTFOUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      count        <= '0;
      limit        <= LIM_W'(DEPTH);
      cmd          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      count        <= count_next;
      cmd          <= cmd_next;
      result_valid <= result_valid_next;
      if (limit_we) begin
        limit <= limit_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_status <= pend_status_next;
    result      <= result_next;
  end

endmodule

@@ hw/rtl/positional_array_list_unit.sv @@
// top level: positional array list built as a row of shifting cells
//
//  channel   direction  handshake                      payload
//  request   in         request_valid / request_stall  pal_req_t
//  result    out        result_valid / result_stall    pal_rsp_t
//  limit     in         limit_we                       limit_data (7 bits)
//
// append, insert, delete and requests rejected on their checks skip the probe: all cells shift at once
// get and find send a probe wave through the 64-cell row, one cell a cycle
// a result waits in its own register, so the next request is taken while it is stalled
// reset clears the length, restores the limit to 64 and empties the result register
// entries are not cleared; slots past the length are never read
module positional_array_list_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       request_valid,
  output logic                       request_stall,
  input  pal_pkg::pal_req_t          request,
  output logic                       result_valid,
  input  logic                       result_stall,
  output pal_pkg::pal_rsp_t          result,
  input  logic                       limit_we,
  input  logic [pal_pkg::LIM_W-1:0]  limit_data
);
  import pal_pkg::*;

  `include "assert_macros.svh"

  pal_cmd_t         cmd;
  logic [VAL_W-1:0] entries [DEPTH];
  pal_probe_t       probes  [DEPTH];
  pal_probe_t       probe_last;
  logic             shifting;
  logic             taking;
  logic             len_ok;

  pal_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .limit_we      (limit_we),
    .limit_data    (limit_data),
    .cmd           (cmd),
    .probe_last    (probe_last),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] below, above;
    pal_probe_t       probe_in;

    if (i == 0) begin : g_first
      assign below    = '0;
      assign probe_in = '0;
    end else begin : g_inner
      assign below    = entries[i-1];
      assign probe_in = probes[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign above = '0;
    end else begin : g_upper
      assign above = entries[i+1];
    end

    pal_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .slot      (IDX_W'(i)),
      .below     (below),
      .above     (above),
      .entry     (entries[i]),
      .probe_in  (probe_in),
      .probe_out (probes[i])
    );
  end

  assign probe_last = probes[DEPTH-1];

  assign shifting = cmd.shift_up || cmd.shift_down;
  assign taking   = request_valid && !request_stall;
  assign len_ok   = (result.list_length <= POS_W'(DEPTH));

  // a shift moves the row exactly once
  `PAL_ASSERT_NEXT(a_shift_once, shifting, !shifting, "shift held past one cycle")
  // no new request while one is being worked on
  `PAL_ASSERT_NEXT(a_busy_after_accept, taking, request_stall, "request taken while busy")
  // an up shift (append or insert) and a down shift (delete) are never issued together
  `PAL_ASSERT_NOW(a_one_shift_dir, 1'b1, !(cmd.shift_up && cmd.shift_down), "both shifts active")
  // reported length stays within the store
  `PAL_ASSERT_NOW(a_length_bound, result_valid, len_ok, "list length beyond store size")

endmodule
